@@ sv/two_way_lru_cache_directory_unit_defines.svh @@
// Assertion macros for the two-way LRU cache directory checker.
`ifndef TWO_WAY_LRU_CACHE_DIRECTORY_UNIT_DEFINES_SVH
`define TWO_WAY_LRU_CACHE_DIRECTORY_UNIT_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define TLRU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tlru check failed");

// Next-cycle implication, ignored while reset is asserted.
`define TLRU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tlru check failed");

// Condition that must hold in the cycle after reset is sampled low.
`define TLRU_ASSERT_RESET(label, clk, rst_n, cons) \
    label: assert property (@(posedge clk) !(rst_n) |=> (cons)) \
        else $error("tlru check failed");

`endif

@@ sv/tlru_pkg.sv @@
// Shared field widths and control types for the two-way LRU cache directory.
package tlru_pkg;

    localparam int ADDRESS_W      = 32;
    localparam int BYTE_OFFSET_W  = 5;
    localparam int BLOCK_NUMBER_W = 27;
    localparam int SET_INDEX_W    = 6;
    localparam int LINE_TAG_W     = 21;
    localparam int COUNT_W        = 32;

    typedef enum logic {
        MODE_CLEAR,
        MODE_RUN
    } mode_t;

endpackage

@@ sv/tlru_row_ram.sv @@
// Simple dual-port set row memory with registered read data.
module tlru_row_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 45,
    parameter int ADDR_W = 6
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/two_way_lru_cache_directory_unit.sv @@
// Top level of the two-way set-associative LRU cache directory.
// Stages: a stage register holds the accepted item; the output registers load on advance.
// Throughput: one item per cycle while m_ready is high; the set row memory is read at accept, written on advance.
// Reset: synchronous, active low; it clears control state and the counters, then a
// clearing pass writes every set row to zero, with s_ready low.
module two_way_lru_cache_directory_unit #(
    parameter int NUM_SETS    = 64,
    parameter int OFFSET_BITS = 5,
    parameter int ADDR_BITS   = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [tlru_pkg::ADDRESS_W-1:0]      s_address,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [tlru_pkg::BYTE_OFFSET_W-1:0]  m_byte_offset,
    output logic [tlru_pkg::BLOCK_NUMBER_W-1:0] m_block_number,
    output logic [tlru_pkg::SET_INDEX_W-1:0]    m_set_index,
    output logic                                m_way_used,
    output logic [tlru_pkg::LINE_TAG_W-1:0]     m_line_tag,
    output logic                                m_is_miss,
    output logic                                m_did_replace,
    output logic [tlru_pkg::LINE_TAG_W-1:0]     m_evicted_tag,
    output logic [tlru_pkg::COUNT_W-1:0]        m_hits_so_far,
    output logic [tlru_pkg::COUNT_W-1:0]        m_misses_so_far
);

    localparam int IN_W     = tlru_pkg::ADDRESS_W;
    localparam int OFF_W    = tlru_pkg::BYTE_OFFSET_W;
    localparam int BLK_W    = tlru_pkg::BLOCK_NUMBER_W;
    localparam int SETO_W   = tlru_pkg::SET_INDEX_W;
    localparam int LTAG_W   = tlru_pkg::LINE_TAG_W;
    localparam int CNT_W    = tlru_pkg::COUNT_W;
    localparam int SET_BITS = $clog2(NUM_SETS);
    localparam int TAG_RAW  = ADDR_BITS - OFFSET_BITS - SET_BITS;
    localparam int TAG_BITS = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int EXT_BITS = IN_W + OFFSET_BITS + SET_BITS + TAG_BITS + BLK_W;
    localparam int ROW_W    = 2 * TAG_BITS + 3;
    localparam int V0_POS   = 2 * TAG_BITS;
    localparam int V1_POS   = 2 * TAG_BITS + 1;
    localparam int LRU_POS  = 2 * TAG_BITS + 2;

    localparam logic [IN_W-1:0] IN_MASK = (ADDR_BITS >= IN_W) ? {IN_W{1'b1}} :
        IN_W'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [OFF_W-1:0] OFF_MASK = (OFFSET_BITS >= OFF_W) ? {OFF_W{1'b1}} :
        OFF_W'((1 << OFFSET_BITS) - 1);
    localparam logic [SETO_W-1:0] SET_MASK = (SET_BITS >= SETO_W) ? {SETO_W{1'b1}} :
        SETO_W'((1 << SET_BITS) - 1);
    localparam logic [SET_BITS-1:0] LAST_SET = SET_BITS'(NUM_SETS - 1);

    tlru_pkg::mode_t mode_reg, mode_next;
    logic [SET_BITS-1:0] clr_cnt_reg;
    logic clearing;

    logic st_valid_reg;
    logic [IN_W-1:0] st_addr_reg;
    logic fwd_reg;
    logic [ROW_W-1:0] fwd_row_reg;

    logic m_valid_reg;
    logic [OFF_W-1:0] m_byte_offset_reg;
    logic [BLK_W-1:0] m_block_number_reg;
    logic [SETO_W-1:0] m_set_index_reg;
    logic m_way_used_reg;
    logic [LTAG_W-1:0] m_line_tag_reg;
    logic m_is_miss_reg;
    logic m_did_replace_reg;
    logic [LTAG_W-1:0] m_evicted_tag_reg;
    logic [CNT_W-1:0] hit_cnt_reg, hit_cnt_next;
    logic [CNT_W-1:0] miss_cnt_reg, miss_cnt_next;

    logic accept;
    logic advance;
    logic [EXT_BITS-1:0] ext_in;
    logic [EXT_BITS-1:0] ext_st;
    logic [SET_BITS-1:0] rd_set;
    logic [SET_BITS-1:0] st_set;
    logic [TAG_BITS-1:0] st_tag;
    logic [ROW_W-1:0] ram_q;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] row_next;
    logic [TAG_BITS-1:0] tag0, tag1;
    logic v0, v1, lru;
    logic hit0, hit1, miss, way, replace;
    logic [TAG_BITS-1:0] ev_tag;
    logic [TAG_BITS+LTAG_W-1:0] ev_wide;
    logic wr_en;
    logic [SET_BITS-1:0] wr_addr;
    logic [ROW_W-1:0] wr_data;

    always_comb begin
        mode_next = mode_reg;
        unique case (mode_reg)
            tlru_pkg::MODE_CLEAR: begin
                if (clr_cnt_reg == LAST_SET) begin
                    mode_next = tlru_pkg::MODE_RUN;
                end
            end
            tlru_pkg::MODE_RUN: mode_next = tlru_pkg::MODE_RUN;
            default: mode_next = tlru_pkg::MODE_CLEAR;
        endcase
    end

    always_comb begin
        unique case (mode_reg)
            tlru_pkg::MODE_CLEAR: clearing = 1'b1;
            tlru_pkg::MODE_RUN:   clearing = 1'b0;
            default:              clearing = 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= tlru_pkg::MODE_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            mode_reg <= mode_next;
            if (clearing) begin
                clr_cnt_reg <= clr_cnt_reg + SET_BITS'(1);
            end
        end
    end

    assign advance = st_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !clearing && (!st_valid_reg || advance);
    assign accept  = s_valid && s_ready;

    assign ext_in = EXT_BITS'(s_address & IN_MASK);
    assign ext_st = EXT_BITS'(st_addr_reg & IN_MASK);
    assign rd_set = ext_in[OFFSET_BITS +: SET_BITS];
    assign st_set = ext_st[OFFSET_BITS +: SET_BITS];
    assign st_tag = ext_st[OFFSET_BITS + SET_BITS +: TAG_BITS];

    assign row  = fwd_reg ? fwd_row_reg : ram_q;
    assign tag0 = row[TAG_BITS-1:0];
    assign tag1 = row[2*TAG_BITS-1:TAG_BITS];
    assign v0   = row[V0_POS];
    assign v1   = row[V1_POS];
    assign lru  = row[LRU_POS];

    always_comb begin
        hit0    = v0 && (tag0 == st_tag);
        hit1    = !hit0 && v1 && (tag1 == st_tag);
        miss    = !hit0 && !hit1;
        replace = miss && v0 && v1;
        if (hit0) begin
            way = 1'b0;
        end else if (hit1) begin
            way = 1'b1;
        end else if (!v0) begin
            way = 1'b0;
        end else if (!v1) begin
            way = 1'b1;
        end else begin
            way = lru;
        end
        if (replace) begin
            ev_tag = lru ? tag1 : tag0;
        end else begin
            ev_tag = '0;
        end
        ev_wide  = {{LTAG_W{1'b0}}, ev_tag};
        row_next = row;
        row_next[LRU_POS] = !way;
        if (miss) begin
            if (way) begin
                row_next[V1_POS] = 1'b1;
                row_next[2*TAG_BITS-1:TAG_BITS] = st_tag;
            end else begin
                row_next[V0_POS] = 1'b1;
                row_next[TAG_BITS-1:0] = st_tag;
            end
        end
        hit_cnt_next  = hit_cnt_reg + CNT_W'(!miss);
        miss_cnt_next = miss_cnt_reg + CNT_W'(miss);
    end

    assign wr_en   = clearing || advance;
    assign wr_addr = clearing ? clr_cnt_reg : st_set;
    assign wr_data = clearing ? '0 : row_next;

    tlru_row_ram #(
        .DEPTH  (NUM_SETS),
        .WIDTH  (ROW_W),
        .ADDR_W (SET_BITS)
    ) u_row_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (rd_set),
        .rd_data (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else if (accept) begin
            st_valid_reg <= 1'b1;
        end else if (advance) begin
            st_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_addr_reg <= s_address;
            fwd_reg     <= wr_en && (wr_addr == rd_set);
            fwd_row_reg <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
        end else begin
            if (advance) begin
                m_valid_reg  <= 1'b1;
                hit_cnt_reg  <= hit_cnt_next;
                miss_cnt_reg <= miss_cnt_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_byte_offset_reg  <= ext_st[OFF_W-1:0] & OFF_MASK;
            m_block_number_reg <= ext_st[OFFSET_BITS +: BLK_W];
            m_set_index_reg    <= ext_st[OFFSET_BITS +: SETO_W] & SET_MASK;
            m_way_used_reg     <= way;
            m_line_tag_reg     <= ext_st[OFFSET_BITS + SET_BITS +: LTAG_W];
            m_is_miss_reg      <= miss;
            m_did_replace_reg  <= replace;
            m_evicted_tag_reg  <= ev_wide[LTAG_W-1:0];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_byte_offset   = m_byte_offset_reg;
    assign m_block_number  = m_block_number_reg;
    assign m_set_index     = m_set_index_reg;
    assign m_way_used      = m_way_used_reg;
    assign m_line_tag      = m_line_tag_reg;
    assign m_is_miss       = m_is_miss_reg;
    assign m_did_replace   = m_did_replace_reg;
    assign m_evicted_tag   = m_evicted_tag_reg;
    assign m_hits_so_far   = hit_cnt_reg;
    assign m_misses_so_far = miss_cnt_reg;

endmodule

@@ sv/tlru_checker.sv @@
// Port-level checker for the two-way LRU cache directory, bound to the top level.
`include "two_way_lru_cache_directory_unit_defines.svh"

module tlru_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic [tlru_pkg::ADDRESS_W-1:0]      s_address,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [tlru_pkg::BYTE_OFFSET_W-1:0]  m_byte_offset,
    input logic [tlru_pkg::BLOCK_NUMBER_W-1:0] m_block_number,
    input logic [tlru_pkg::SET_INDEX_W-1:0]    m_set_index,
    input logic                                m_way_used,
    input logic [tlru_pkg::LINE_TAG_W-1:0]     m_line_tag,
    input logic                                m_is_miss,
    input logic                                m_did_replace,
    input logic [tlru_pkg::LINE_TAG_W-1:0]     m_evicted_tag,
    input logic [tlru_pkg::COUNT_W-1:0]        m_hits_so_far,
    input logic [tlru_pkg::COUNT_W-1:0]        m_misses_so_far
);

    localparam int OUT_W = tlru_pkg::BYTE_OFFSET_W + tlru_pkg::BLOCK_NUMBER_W
        + tlru_pkg::SET_INDEX_W + 2 * tlru_pkg::LINE_TAG_W + 2 * tlru_pkg::COUNT_W + 3;

    logic [OUT_W-1:0] out_bits;

    assign out_bits = {m_byte_offset, m_block_number, m_set_index, m_way_used, m_line_tag,
                       m_is_miss, m_did_replace, m_evicted_tag, m_hits_so_far,
                       m_misses_so_far};

    `TLRU_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(out_bits))
    `TLRU_ASSERT_NEXT(a_in_hold, aclk, aresetn, s_valid && !s_ready, s_valid && $stable(s_address))
    `TLRU_ASSERT_IMPLY(a_replace_is_miss, aclk, aresetn, m_valid && m_did_replace, m_is_miss)
    `TLRU_ASSERT_IMPLY(a_no_evict_zero, aclk, aresetn, m_valid && !m_did_replace, m_evicted_tag == '0)
    `TLRU_ASSERT_RESET(a_reset_idle, aclk, aresetn, !m_valid && !s_ready)

endmodule

bind two_way_lru_cache_directory_unit tlru_checker u_tlru_checker (.*);
